FILE: hw/rtl/cea861_data_block_parser_defines.svh
// ----------------------------------------------------------------------------
// CEA-861 data block parser assertion macros
// Shared macros for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef CEA861_DATA_BLOCK_PARSER_DEFINES_SVH
`define CEA861_DATA_BLOCK_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CDBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CDBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cdbp_pkg.sv
// ----------------------------------------------------------------------------
// CEA-861 data block parser package
// Constants, data block tags and the summary record type.
// ----------------------------------------------------------------------------
package cdbp_pkg;

    localparam int MAX_SAD   = 16;
    localparam int SAD_SLOTS = 16;
    localparam int SAD_CAP   = (MAX_SAD < SAD_SLOTS) ? MAX_SAD : SAD_SLOTS;

    localparam logic [4:0] SAD_CAP_W = 5'(SAD_CAP);
    localparam logic [6:0] LAST_POS  = 7'd127;
    localparam logic [7:0] FIRST_HDR = 8'd4;

    // data block tags
    localparam logic [2:0] TAG_AUDIO   = 3'd1;
    localparam logic [2:0] TAG_VENDOR  = 3'd3;
    localparam logic [2:0] TAG_SPEAKER = 3'd4;

    // HDMI IEEE OUI, payload bytes 1 to 3
    localparam logic [7:0] OUI_B0 = 8'h03;
    localparam logic [7:0] OUI_B1 = 8'h0c;
    localparam logic [7:0] OUI_B2 = 8'h00;

    localparam logic [1:0] ELD_VER_2 = 2'd2;

    // result kinds
    localparam logic ITEM_SAD     = 1'b0;
    localparam logic ITEM_SUMMARY = 1'b1;

    typedef struct packed {
        logic [1:0]  eld_version;
        logic [7:0]  cea_revision;
        logic [4:0]  sad_total;
        logic [7:0]  speaker_alloc;
        logic [15:0] port_address;
        logic        supports_ai;
        logic [7:0]  audio_sync_delay;
        logic        stereo_3d;
    } t_record;

endpackage

FILE: hw/rtl/cea861_data_block_parser.sv
// ----------------------------------------------------------------------------
// CEA-861 data block parser
// Parses one EDID extension block a byte per transfer and reports the short
// audio descriptors and an HDMI summary record.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one extension block byte
//   per transfer, byte 0 first; i_block_end marks the final byte.
//   Bytes are taken one per cycle outside a result run, whether or not the
//   output side is stalled, since no result exists until the end of the block.
//   The final byte starts a result run on the output channel
//   (o_out_valid / i_out_ready): min(sad_total, 16) descriptor items, then one
//   summary item with o_last high. The final byte's transfer sets the run flag,
//   which then loads the first item into the output register; with i_out_ready
//   held high, one item per cycle leaves the output register.
//   o_in_ready is low for the whole run; the parser state clears when the
//   summary is loaded, and input opens again on the next cycle.
//   Bytes past 127 are dropped until the end marker.
//   Reset (i_rst_n low, synchronous) clears the parse state and any run in
//   progress. A stalled receiver holds the current output item in place and
//   simply lengthens the run.
// ----------------------------------------------------------------------------
`include "cea861_data_block_parser_defines.svh"

module cea861_data_block_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_block_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_item_kind,
    output logic [3:0]  o_sad_index,
    output logic [7:0]  o_sad_value,
    output logic [1:0]  o_eld_version,
    output logic [7:0]  o_cea_revision,
    output logic [4:0]  o_sad_total,
    output logic [7:0]  o_speaker_alloc,
    output logic [15:0] o_port_address,
    output logic        o_supports_ai,
    output logic [7:0]  o_audio_sync_delay,
    output logic        o_stereo_3d,
    output logic        o_last
);
    import cdbp_pkg::*;

    // parse state
    logic [6:0] r_byte_pos,    n_byte_pos;
    logic       r_full,        n_full;
    logic [7:0] r_timing_off,  n_timing_off;
    logic       r_plain_audio, n_plain_audio;
    logic [7:0] r_next_hdr,    n_next_hdr;
    logic [2:0] r_tag,         n_tag;
    logic [4:0] r_blk_len,     n_blk_len;
    logic [4:0] r_pay_off,     n_pay_off;
    logic       r_oui_ok,      n_oui_ok;
    logic [4:0] r_stereo_at,   n_stereo_at;
    t_record    r_rec,         n_rec;

    // descriptor store, no reset
    logic [7:0] r_sad [SAD_SLOTS];
    logic       w_sad_we;
    logic [3:0] w_sad_addr;

    // result run
    logic       r_emit, n_emit;
    logic [4:0] r_idx,  n_idx;
    logic [4:0] w_count;
    logic       w_load;
    logic       w_at_summary;
    logic       w_in_xfer;

    // output register
    logic       r_out_valid;
    logic       r_out_kind;
    logic [3:0] r_out_index;
    logic [7:0] r_out_value;
    t_record    r_out_rec;
    logic       r_out_last;

    // per-byte decode
    logic [7:0] w_pos8;
    logic [4:0] w_k;
    logic [4:0] w_k_m1;
    logic [4:0] w_stereo_new;
    logic [7:0] w_b;

    assign o_in_ready   = !r_emit;
    assign w_in_xfer    = i_in_valid && o_in_ready;
    assign w_count      = (r_rec.sad_total > SAD_CAP_W) ? SAD_CAP_W : r_rec.sad_total;
    assign w_load       = r_emit && (!r_out_valid || i_out_ready);
    assign w_at_summary = (r_idx >= w_count);

    assign w_b          = i_data_byte;
    assign w_pos8       = {1'b0, r_byte_pos};
    assign w_k          = r_pay_off + 5'd1;
    assign w_k_m1       = r_pay_off;
    assign w_sad_addr   = w_k_m1[3:0];
    assign w_stereo_new = w_b[5] ? (5'd9 + {3'b000, w_b[7], 1'b0} + {3'b000, w_b[6], 1'b0})
                                 : 5'd0;

    always_comb begin
        n_byte_pos    = r_byte_pos;
        n_full        = r_full;
        n_timing_off  = r_timing_off;
        n_plain_audio = r_plain_audio;
        n_next_hdr    = r_next_hdr;
        n_tag         = r_tag;
        n_blk_len     = r_blk_len;
        n_pay_off     = r_pay_off;
        n_oui_ok      = r_oui_ok;
        n_stereo_at   = r_stereo_at;
        n_rec         = r_rec;
        n_emit        = r_emit;
        n_idx         = r_idx;
        w_sad_we      = 1'b0;

        if (w_in_xfer && !r_full) begin
            if (r_byte_pos == 7'd0) begin
                n_rec.eld_version = (w_b <= 8'd3) ? ELD_VER_2 : 2'd0;
            end else if (r_byte_pos == 7'd1) begin
                n_rec.cea_revision = w_b;
            end else if (r_byte_pos == 7'd2) begin
                n_timing_off = w_b;
            end else if (r_byte_pos == 7'd3) begin
                n_plain_audio = w_b[6];
            end else if (w_pos8 == r_next_hdr) begin
                // header: take it only below the detailed-timing offset
                if (w_pos8 < r_timing_off) begin
                    n_tag       = w_b[7:5];
                    n_blk_len   = w_b[4:0];
                    n_pay_off   = 5'd0;
                    n_oui_ok    = 1'b0;
                    n_stereo_at = 5'd0;
                    n_next_hdr  = w_pos8 + {3'b000, w_b[4:0]} + 8'd1;
                    if (w_b[7:5] == TAG_AUDIO) begin
                        n_rec.sad_total = w_b[4:0];
                        if (r_plain_audio) begin
                            n_rec.speaker_alloc = 8'd1;
                        end
                    end
                end
            end else if (w_pos8 < r_next_hdr) begin
                n_pay_off = w_k;
                if (w_k != 5'd0 && w_k <= r_blk_len) begin
                    case (r_tag)
                        TAG_AUDIO: begin
                            w_sad_we = (w_k_m1 < SAD_CAP_W);
                        end
                        TAG_SPEAKER: begin
                            if (w_k == 5'd1) begin
                                n_rec.speaker_alloc = w_b;
                            end
                        end
                        TAG_VENDOR: begin
                            if (w_k == 5'd1) begin
                                n_oui_ok = (w_b == OUI_B0);
                            end else if (w_k == 5'd2) begin
                                n_oui_ok = r_oui_ok && (w_b == OUI_B1);
                            end else if (w_k == 5'd3) begin
                                n_oui_ok = r_oui_ok && (w_b == OUI_B2);
                            end else if (r_oui_ok) begin
                                if (w_k == 5'd4) begin
                                    n_rec.port_address[15:8] = w_b;
                                end else if (w_k == 5'd5) begin
                                    n_rec.port_address[7:0] = w_b;
                                end else if (w_k == 5'd6) begin
                                    n_rec.supports_ai = w_b[7];
                                end else if (w_k == 5'd8) begin
                                    n_stereo_at = w_stereo_new;
                                end
                                if (w_k == 5'd10) begin
                                    n_rec.audio_sync_delay = w_b;
                                end
                                // a fresh check position never equals byte 8
                                if (r_stereo_at != 5'd0 && w_k == r_stereo_at && w_b[7]) begin
                                    n_rec.stereo_3d = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            if (r_byte_pos >= LAST_POS) begin
                n_full = 1'b1;
            end else begin
                n_byte_pos = r_byte_pos + 7'd1;
            end
        end

        if (w_in_xfer && i_block_end) begin
            n_emit = 1'b1;
            n_idx  = 5'd0;
        end

        if (w_load) begin
            if (w_at_summary) begin
                // summary leaves: return the parser to its reset state
                n_emit        = 1'b0;
                n_idx         = 5'd0;
                n_byte_pos    = 7'd0;
                n_full        = 1'b0;
                n_timing_off  = 8'd0;
                n_plain_audio = 1'b0;
                n_next_hdr    = FIRST_HDR;
                n_tag         = 3'd0;
                n_blk_len     = 5'd0;
                n_pay_off     = 5'd0;
                n_oui_ok      = 1'b0;
                n_stereo_at   = 5'd0;
                n_rec         = '0;
            end else begin
                n_idx = r_idx + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos    <= 7'd0;
            r_full        <= 1'b0;
            r_timing_off  <= 8'd0;
            r_plain_audio <= 1'b0;
            r_next_hdr    <= FIRST_HDR;
            r_tag         <= 3'd0;
            r_blk_len     <= 5'd0;
            r_pay_off     <= 5'd0;
            r_oui_ok      <= 1'b0;
            r_stereo_at   <= 5'd0;
            r_rec         <= '0;
            r_emit        <= 1'b0;
            r_idx         <= 5'd0;
        end else begin
            r_byte_pos    <= n_byte_pos;
            r_full        <= n_full;
            r_timing_off  <= n_timing_off;
            r_plain_audio <= n_plain_audio;
            r_next_hdr    <= n_next_hdr;
            r_tag         <= n_tag;
            r_blk_len     <= n_blk_len;
            r_pay_off     <= n_pay_off;
            r_oui_ok      <= n_oui_ok;
            r_stereo_at   <= n_stereo_at;
            r_rec         <= n_rec;
            r_emit        <= n_emit;
            r_idx         <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sad_we) begin
            r_sad[w_sad_addr] <= w_b;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_at_summary) begin
                r_out_kind  <= ITEM_SUMMARY;
                r_out_index <= 4'd0;
                r_out_value <= 8'd0;
                r_out_rec   <= r_rec;
                r_out_last  <= 1'b1;
            end else begin
                r_out_kind  <= ITEM_SAD;
                r_out_index <= r_idx[3:0];
                r_out_value <= r_sad[r_idx[3:0]];
                r_out_rec   <= '0;
                r_out_last  <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_item_kind        = r_out_kind;
    assign o_sad_index        = r_out_index;
    assign o_sad_value        = r_out_value;
    assign o_eld_version      = r_out_rec.eld_version;
    assign o_cea_revision     = r_out_rec.cea_revision;
    assign o_sad_total        = r_out_rec.sad_total;
    assign o_speaker_alloc    = r_out_rec.speaker_alloc;
    assign o_port_address     = r_out_rec.port_address;
    assign o_supports_ai      = r_out_rec.supports_ai;
    assign o_audio_sync_delay = r_out_rec.audio_sync_delay;
    assign o_stereo_3d        = r_out_rec.stereo_3d;
    assign o_last             = r_out_last;

    // end marker must open a result run
    `CDBP_ASSERT_NEXT(a_end_starts_run, w_in_xfer && i_block_end, r_emit && r_idx == 5'd0, "end marker did not start a result run")
    // summary load must return the parser to its start state
    `CDBP_ASSERT_NEXT(a_summary_clears, w_load && w_at_summary, !r_emit && r_byte_pos == 7'd0 && r_rec == '0, "parser state not cleared after summary")
    // a pending descriptor item lies within the descriptor count
    `CDBP_ASSERT_NOW(a_sad_in_range, r_out_valid && r_out_kind == ITEM_SAD, r_emit && 5'(r_out_index) < w_count, "descriptor index beyond count")

endmodule

FILE: test/tb_cea861_data_block_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CEA-861 data block parser testbench
// Streams EDID extension blocks into the parser: two short directed blocks, then
// random blocks of mostly well-formed data block layouts, with bursty input
// and a stalling receiver. A scoreboard parses every accepted byte on its own
// and compares each descriptor and summary item with what it predicts.
// ----------------------------------------------------------------------------
module tb_cea861_data_block_parser;
    import cdbp_pkg::*;

    localparam int ITEM_TARGET = 410;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN       = 40;
    localparam int BLOCK_BYTES = 128;

    typedef struct packed {
        logic       kind;
        logic [3:0] sad_index;
        logic [7:0] sad_value;
        t_record    rec;
        logic       last;
    } t_eld_item;

    typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_THIRD, RX_SPARSE} t_rx_mode;

    // Parses the byte stream alongside the parser and keeps the items that
    // each block end is due to produce.
    class t_eld_tracker;
        bit [6:0]           byte_pos;
        bit                 pos_frozen;
        bit [7:0]           dtd_offset;
        bit                 plain_audio;
        bit [7:0]           next_hdr;
        bit [2:0]           tag;
        bit [4:0]           blen;
        bit [4:0]           poff;
        bit                 hdmi_oui;
        bit [4:0]           stereo_at;
        bit [7:0]           sads [SAD_SLOTS];
        bit [SAD_SLOTS-1:0] sad_written;
        t_record            rec;
        t_eld_item          pending_items [$];
        int                 mismatches;

        function new();
            clear();
            mismatches = 0;
        endfunction

        function void clear();
            byte_pos    = '0;
            pos_frozen  = 1'b0;
            dtd_offset  = '0;
            plain_audio = 1'b0;
            next_hdr    = FIRST_HDR;
            tag         = '0;
            blen        = '0;
            poff        = '0;
            hdmi_oui    = 1'b0;
            stereo_at   = '0;
            sad_written = '0;
            rec         = '0;
        endfunction

        function int pending();
            return pending_items.size();
        endfunction

        function int desc_count();
            return (rec.sad_total > SAD_CAP_W) ? SAD_CAP : int'(rec.sad_total);
        endfunction

        // True when ending the block now emits only descriptors written in it.
        function bit run_defined();
            for (int i = 0; i < desc_count(); i++)
                if (!sad_written[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void start_block(bit [7:0] b);
            tag       = b[7:5];
            blen      = b[4:0];
            poff      = '0;
            hdmi_oui  = 1'b0;
            stereo_at = '0;
            next_hdr  = {1'b0, byte_pos} + 8'(blen) + 8'd1;
            if (tag == TAG_AUDIO) begin
                rec.sad_total = blen;
                if (plain_audio)
                    rec.speaker_alloc = 8'd1;
            end
        endfunction

        function void vendor_byte(bit [4:0] k, bit [7:0] b);
            case (k)
                5'd1: hdmi_oui = (b == OUI_B0);
                5'd2: hdmi_oui = hdmi_oui && (b == OUI_B1);
                5'd3: hdmi_oui = hdmi_oui && (b == OUI_B2);
                default: begin
                    if (hdmi_oui) begin
                        case (k)
                            5'd4:  rec.port_address[15:8] = b;
                            5'd5:  rec.port_address[7:0] = b;
                            5'd6:  rec.supports_ai = b[7];
                            5'd8: begin
                                // the 3D flag sits after the optional latency pairs
                                stereo_at = '0;
                                if (b[5])
                                    stereo_at = 5'd9 + (b[7] ? 5'd2 : 5'd0)
                                                     + (b[6] ? 5'd2 : 5'd0);
                            end
                            5'd10: rec.audio_sync_delay = b;
                            default: ;
                        endcase
                        if (stereo_at != 0 && k == stereo_at && b[7])
                            rec.stereo_3d = 1'b1;
                    end
                end
            endcase
        endfunction

        function void payload_byte(bit [7:0] b);
            bit [4:0] k;
            poff = poff + 5'd1;
            k = poff;
            if (k == 0 || k > blen)
                return;
            if (tag == TAG_AUDIO) begin
                if (int'(k) - 1 < SAD_CAP) begin
                    sads[k - 1] = b;
                    sad_written[k - 1] = 1'b1;
                end
            end else if (tag == TAG_VENDOR) begin
                vendor_byte(k, b);
            end else if (tag == TAG_SPEAKER && k == 1) begin
                rec.speaker_alloc = b;
            end
        endfunction

        function void absorb(bit [7:0] b);
            if (pos_frozen)
                return;
            case (byte_pos)
                7'd0: rec.eld_version = (b <= 8'd3) ? ELD_VER_2 : '0;
                7'd1: rec.cea_revision = b;
                7'd2: dtd_offset = b;
                7'd3: plain_audio = b[6];
                default: begin
                    if ({1'b0, byte_pos} == next_hdr) begin
                        if ({1'b0, byte_pos} < dtd_offset)
                            start_block(b);
                    end else if ({1'b0, byte_pos} < next_hdr) begin
                        payload_byte(b);
                    end
                end
            endcase
            if (byte_pos == LAST_POS)
                pos_frozen = 1'b1;
            else
                byte_pos = byte_pos + 7'd1;
        endfunction

        function void note_byte(bit [7:0] b, bit block_end);
            t_eld_item item;
            absorb(b);
            if (!block_end)
                return;
            for (int i = 0; i < desc_count(); i++) begin
                item = '0;
                item.kind = ITEM_SAD;
                item.sad_index = 4'(i);
                item.sad_value = sads[i];
                pending_items.push_back(item);
            end
            item = '0;
            item.kind = ITEM_SUMMARY;
            item.rec  = rec;
            item.last = 1'b1;
            pending_items.push_back(item);
            clear();
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_item(t_eld_item got);
            t_eld_item want;
            if (pending_items.size() == 0) begin
                $error("unexpected output transfer: kind %0d index %0d",
                       got.kind, got.sad_index);
                mismatches++;
                return;
            end
            want = pending_items.pop_front();
            check_field("item_kind", want.kind, got.kind);
            check_field("sad_index", want.sad_index, got.sad_index);
            check_field("sad_value", want.sad_value, got.sad_value);
            check_field("eld_version", want.rec.eld_version, got.rec.eld_version);
            check_field("cea_revision", want.rec.cea_revision, got.rec.cea_revision);
            check_field("sad_total", want.rec.sad_total, got.rec.sad_total);
            check_field("speaker_alloc", want.rec.speaker_alloc, got.rec.speaker_alloc);
            check_field("port_address", want.rec.port_address, got.rec.port_address);
            check_field("supports_ai", want.rec.supports_ai, got.rec.supports_ai);
            check_field("audio_sync_delay", want.rec.audio_sync_delay,
                        got.rec.audio_sync_delay);
            check_field("stereo_3d", want.rec.stereo_3d, got.rec.stereo_3d);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_block_end;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_item_kind;
    logic [3:0]  o_sad_index;
    logic [7:0]  o_sad_value;
    logic [1:0]  o_eld_version;
    logic [7:0]  o_cea_revision;
    logic [4:0]  o_sad_total;
    logic [7:0]  o_speaker_alloc;
    logic [15:0] o_port_address;
    logic        o_supports_ai;
    logic [7:0]  o_audio_sync_delay;
    logic        o_stereo_3d;
    logic        o_last;

    t_eld_tracker tracker;
    t_eld_tracker probe;
    t_eld_item    seen;
    logic [7:0]   blk [$];
    int           safe_ends [$];
    int           items_sent;
    int           burst_left;
    int           cycle_count;

    cea861_data_block_parser u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_block_end        (i_block_end),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_item_kind        (o_item_kind),
        .o_sad_index        (o_sad_index),
        .o_sad_value        (o_sad_value),
        .o_eld_version      (o_eld_version),
        .o_cea_revision     (o_cea_revision),
        .o_sad_total        (o_sad_total),
        .o_speaker_alloc    (o_speaker_alloc),
        .o_port_address     (o_port_address),
        .o_supports_ai      (o_supports_ai),
        .o_audio_sync_delay (o_audio_sync_delay),
        .o_stereo_3d        (o_stereo_3d),
        .o_last             (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Values read here are the ones settled before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                tracker.note_byte(i_data_byte, i_block_end);
            if (o_out_valid && i_out_ready) begin
                seen = '0;
                seen.kind                 = o_item_kind;
                seen.sad_index            = o_sad_index;
                seen.sad_value            = o_sad_value;
                seen.rec.eld_version      = o_eld_version;
                seen.rec.cea_revision     = o_cea_revision;
                seen.rec.sad_total        = o_sad_total;
                seen.rec.speaker_alloc    = o_speaker_alloc;
                seen.rec.port_address     = o_port_address;
                seen.rec.supports_ai      = o_supports_ai;
                seen.rec.audio_sync_delay = o_audio_sync_delay;
                seen.rec.stereo_3d        = o_stereo_3d;
                seen.last                 = o_last;
                tracker.check_item(seen);
            end
        end
    end

    initial begin : out_stall
        t_rx_mode mode;
        int       span;
        int       tick;
        bit       was_valid;
        bit       held_once;
        i_out_ready <= 1'b0;
        was_valid = 1'b0;
        held_once = 1'b0;
        tick = 0;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(posedge i_clk);
                tick++;
                if (i_rst_n && o_out_valid && !was_valid &&
                    (!held_once || $urandom_range(0, 7) == 0)) begin
                    // hold the run so the sender backs up behind it
                    held_once = 1'b1;
                    i_out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                was_valid = o_out_valid;
                case (mode)
                    RX_OPEN:        i_out_ready <= 1'b1;
                    RX_COIN:        i_out_ready <= 1'($urandom_range(0, 1));
                    RX_EVERY_THIRD: i_out_ready <= (tick % 3 != 0);
                    default:        i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic block_end);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) == 0) begin
                gap = 0;
                burst_left = $urandom_range(50, 200);
            end else begin
                gap = $urandom_range(1, 8);
                burst_left = $urandom_range(1, 30);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_block_end <= block_end;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_block();
        for (int i = 0; i < blk.size(); i++)
            send_byte(blk[i], i == blk.size() - 1);
    endtask

    // Build one extension block in blk and cut it at an end position that
    // never emits a descriptor slot left unwritten in this block.
    task automatic make_block();
        int         region;
        int         len;
        int         r;
        int         dtd;
        int         cut;
        bit         oui;
        logic [2:0] tag;
        logic [7:0] b;
        blk.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat (BLOCK_BYTES) blk.push_back(8'($urandom));
        end else begin
            blk.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(4, 255))
                                                      : 8'($urandom_range(0, 3)));
            blk.push_back(8'($urandom));
            blk.push_back(8'h00);
            blk.push_back(8'($urandom));
            region = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 123)
                                                 : $urandom_range(0, 50);
            while (blk.size() < 4 + region) begin
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    tag = TAG_AUDIO;
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                      : 3 * $urandom_range(1, 10);
                end else if (r < 6) begin
                    tag = TAG_VENDOR;
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                      : $urandom_range(8, 20);
                end else if (r < 8) begin
                    tag = TAG_SPEAKER;
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : 3;
                end else begin
                    do
                        tag = 3'($urandom);
                    while (tag == TAG_AUDIO || tag == TAG_VENDOR || tag == TAG_SPEAKER);
                    len = $urandom_range(0, 31);
                end
                oui = (tag == TAG_VENDOR) && ($urandom_range(0, 3) != 0);
                blk.push_back({tag, 5'(len)});
                for (int k = 1; k <= len; k++) begin
                    b = 8'($urandom);
                    if (oui && k == 1)
                        b = OUI_B0;
                    else if (oui && k == 2)
                        b = OUI_B1;
                    else if (oui && k == 3)
                        b = OUI_B2;
                    else if (oui && k == 8 && $urandom_range(0, 3) != 0)
                        b[5] = 1'b1;
                    blk.push_back(b);
                end
            end
            while (blk.size() > BLOCK_BYTES)
                void'(blk.pop_back());
            // timing offset usually right after the data blocks
            dtd = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : blk.size();
            blk[2] = 8'(dtd);
            while (blk.size() < BLOCK_BYTES)
                blk.push_back(8'($urandom));
        end

        r = $urandom_range(0, 9);
        if (r == 4)
            repeat ($urandom_range(1, 8)) blk.push_back(8'($urandom));
        probe.clear();
        safe_ends.delete();
        for (int i = 0; i < blk.size(); i++) begin
            probe.absorb(blk[i]);
            if (probe.run_defined())
                safe_ends.push_back(i);
        end
        // keep the total near the item budget
        while (safe_ends.size() > 1 &&
               safe_ends[safe_ends.size() - 1] >= ITEM_TARGET - items_sent)
            void'(safe_ends.pop_back());
        if (r <= 4)
            cut = safe_ends[safe_ends.size() - 1];
        else
            cut = safe_ends[$urandom_range(0, safe_ends.size() - 1)];
        while (blk.size() > cut + 1)
            void'(blk.pop_back());
    endtask

    initial begin : stimulus
        tracker = new();
        probe   = new();
        items_sent  = 0;
        burst_left  = 0;
        cycle_count = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= '0;
        i_block_end <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // speaker, HDMI vendor block with 3D present, then audio with basic audio
        blk = '{8'h03, 8'hff, 8'hff, 8'h40,
                8'h81, 8'h5a,
                8'h6d, 8'h03, 8'h0c, 8'h00, 8'hff, 8'hff, 8'h80, 8'h00, 8'he0,
                8'h00, 8'hff, 8'h00, 8'h00, 8'h80,
                8'h23, 8'hff, 8'h00, 8'h81};
        send_block();
        // block ended on its first byte
        blk = '{8'hff};
        send_block();

        while (items_sent < ITEM_TARGET) begin
            make_block();
            send_block();
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
